// File: sv/esq_pkg.sv
// ----------------------------------------------------------------------------
// esq_pkg: shared types and constants
// Widths, opcodes and status codes of the event subscription queues.
// ----------------------------------------------------------------------------
package esq_pkg;
   localparam int Subscribers = 8;
   localparam int QueueDepth  = 64;
   localparam int EventBits   = 32;
   localparam int PullMax     = 64;
   localparam int SlotBits    = $clog2(Subscribers);
   localparam int PosBits     = $clog2(QueueDepth);
   localparam int FillBits    = $clog2(QueueDepth + 1);
   localparam int AddrBits    = SlotBits + PosBits;

   localparam logic [2:0] OP_CREATE = 3'd0;
   localparam logic [2:0] OP_PUSH   = 3'd1;
   localparam logic [2:0] OP_PULL   = 3'd2;
   localparam logic [2:0] OP_RENEW  = 3'd3;
   localparam logic [2:0] OP_UNSUB  = 3'd4;
   localparam logic [2:0] OP_TICK   = 3'd5;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_DEAD = 2'd2;

   localparam logic CSR_DEFAULT_TERM = 1'b0;
   localparam logic CSR_MAX_TERM     = 1'b1;

   typedef struct packed {
      logic [2:0]  opcode;
      logic [2:0]  slot_index;
      logic [15:0] requested_term;
      logic [31:0] event_word;
      logic        event_is_property;
      logic [7:0]  message_limit;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [2:0]  result_slot;
      logic [31:0] pulled_event;
      logic        pulled_is_property;
      logic        has_event;
      logic [31:0] end_time;
      logic        last;
   } rsp_type;
endpackage

// File: sv/esq_req_if.sv
// ----------------------------------------------------------------------------
// esq_req_if: request channel
// Valid/ready channel carrying one operation request.
// ----------------------------------------------------------------------------
interface esq_req_if;
   logic             valid;
   logic             ready;
   esq_pkg::req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: sv/esq_rsp_if.sv
// ----------------------------------------------------------------------------
// esq_rsp_if: result channel
// Valid/ready channel carrying one result.
// ----------------------------------------------------------------------------
interface esq_rsp_if;
   logic             valid;
   logic             ready;
   esq_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: sv/event_subscription_queues_unit.sv
// ----------------------------------------------------------------------------
// event_subscription_queues_unit: subscriber pool with per-slot event rings
// Create, push, pull, renew, unsubscribe and tick over eight slots.
// ----------------------------------------------------------------------------
// One request is taken at a time, and only once the result register is empty.
// A sequencer visits the slots one per cycle through a single shared 33-bit
// add/compare unit. Create, push and tick scan every slot, then pass the
// closing and output steps to a valid result. Renew, unsubscribe, unknown
// opcodes and a pull of a dead or empty slot go from the closing step
// straight to the output step. A pull that returns events checks the slot
// in the closing step, then reads the ring memory one entry at a time
// through its single read port: each event is read into a register, then
// loaded into the result register once the result side has room. The ring
// memory needs no clearing pass after reset.
module event_subscription_queues_unit (
   input  logic        clock,
   input  logic        reset,
   esq_req_if.sink     req,
   esq_rsp_if.source   rsp,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_FIN  = 3'd2;
   localparam logic [2:0] S_READ = 3'd3;
   localparam logic [2:0] S_EMIT = 3'd4;
   localparam logic [2:0] S_OUT  = 3'd5;

   localparam logic [esq_pkg::SlotBits:0] SlotCount =
      (esq_pkg::SlotBits+1)'(esq_pkg::Subscribers);

   logic [2:0]  state_ff, state_in;
   logic [15:0] def_term_ff, max_term_ff;
   logic [esq_pkg::Subscribers-1:0] active_ff;
   logic [31:0] end_ff [esq_pkg::Subscribers];
   logic [31:0] now_ff;
   logic [esq_pkg::PosBits-1:0]  wpos_ff [esq_pkg::Subscribers];
   logic [esq_pkg::PosBits-1:0]  rpos_ff [esq_pkg::Subscribers];
   logic [esq_pkg::FillBits-1:0] fill_ff [esq_pkg::Subscribers];
   logic [esq_pkg::EventBits:0]  ring [esq_pkg::Subscribers * esq_pkg::QueueDepth];
   logic [esq_pkg::EventBits:0]  rdata_ff;

   esq_pkg::req_type op_ff;
   esq_pkg::rsp_type out_ff;
   esq_pkg::rsp_type fin_rsp;
   logic        out_vld_ff, out_vld_in;
   logic [esq_pkg::SlotBits:0] cnt_ff;
   logic [6:0]  left_ff;
   logic        found_ff;
   logic [esq_pkg::SlotBits-1:0] fslot_ff;

   // shared add/compare unit
   logic [esq_pkg::SlotBits-1:0] cur;
   logic [15:0] term;
   logic [32:0] sum;
   logic [31:0] new_end;
   logic        expired;
   logic        in_range;
   logic        pull_live;
   logic [6:0]  pull_lim;
   logic [esq_pkg::SlotBits-1:0] idx;

   assign idx      = op_ff.slot_index[esq_pkg::SlotBits-1:0];
   assign in_range = ({1'b0, op_ff.slot_index} < 4'(esq_pkg::Subscribers));
   assign cur      = (state_ff == S_SCAN) ? cnt_ff[esq_pkg::SlotBits-1:0] : idx;
   always_comb begin
      if (op_ff.requested_term == 16'd0) term = def_term_ff;
      else if (op_ff.requested_term > max_term_ff) term = max_term_ff;
      else term = op_ff.requested_term;
   end
   assign sum     = {1'b0, now_ff} + {17'd0, term};
   assign new_end = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
   assign expired = now_ff >= end_ff[cur];

   // pull: slot must be live; limit of zero counts as one, clamp at the maximum
   assign pull_live = in_range && active_ff[idx] && !expired;
   always_comb begin
      if (op_ff.message_limit == 8'd0) pull_lim = 7'd1;
      else if (op_ff.message_limit > 8'(esq_pkg::PullMax)) pull_lim = 7'(esq_pkg::PullMax);
      else pull_lim = op_ff.message_limit[6:0];
   end

   logic [esq_pkg::AddrBits-1:0] raddr;
   assign raddr = {idx, rpos_ff[idx]};

   assign req.ready = (state_ff == S_IDLE) && !out_vld_ff;
   assign rsp.valid = out_vld_ff;
   assign rsp.data  = out_ff;

   // hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         def_term_ff <= 16'd60;
         max_term_ff <= 16'd3600;
      end else if (csr_write) begin
         if (csr_index == esq_pkg::CSR_DEFAULT_TERM) def_term_ff <= csr_wdata;
         else max_term_ff <= csr_wdata;
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req.valid && req.ready) begin
            state_in = (req.data.opcode == esq_pkg::OP_CREATE ||
                        req.data.opcode == esq_pkg::OP_PUSH ||
                        req.data.opcode == esq_pkg::OP_TICK) ? S_SCAN : S_FIN;
         end
         S_SCAN: if (cnt_ff == SlotCount - 1'b1) state_in = S_FIN;
         S_FIN: begin
            if (op_ff.opcode == esq_pkg::OP_PULL && pull_live && fill_ff[idx] != '0)
               state_in = S_READ;
            else state_in = S_OUT;
         end
         S_READ: state_in = S_EMIT;
         S_EMIT: if (!out_vld_ff || rsp.ready) state_in = (left_ff == 7'd1) ? S_IDLE : S_READ;
         S_OUT:  if (!out_vld_ff || rsp.ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // result register valid: drop on acceptance, load from emit or out
   always_comb begin
      out_vld_in = out_vld_ff && !rsp.ready;
      if ((state_ff == S_EMIT || state_ff == S_OUT) && (!out_vld_ff || rsp.ready))
         out_vld_in = 1'b1;
   end

   // result of the closing step of a request
   always_comb begin
      fin_rsp      = '0;
      fin_rsp.last = 1'b1;
      case (op_ff.opcode)
         esq_pkg::OP_CREATE: begin
            if (found_ff) begin
               fin_rsp.result_slot = 3'(fslot_ff);
               fin_rsp.end_time    = new_end;
            end else fin_rsp.status = esq_pkg::ST_FULL;
         end
         esq_pkg::OP_PULL: begin
            fin_rsp.result_slot = op_ff.slot_index;
            if (!pull_live) fin_rsp.status = esq_pkg::ST_DEAD;
            else fin_rsp.end_time = end_ff[idx];
         end
         esq_pkg::OP_RENEW: begin
            fin_rsp.result_slot = op_ff.slot_index;
            if (!in_range || !active_ff[idx]) fin_rsp.status = esq_pkg::ST_DEAD;
            else fin_rsp.end_time = new_end;
         end
         esq_pkg::OP_UNSUB: begin
            fin_rsp.result_slot = op_ff.slot_index;
            if (!in_range || !active_ff[idx]) fin_rsp.status = esq_pkg::ST_DEAD;
            else fin_rsp.end_time = end_ff[idx];
         end
         default: ;
      endcase
   end

   // ring memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (state_ff == S_SCAN && op_ff.opcode == esq_pkg::OP_PUSH && active_ff[cur] && !expired)
         ring[{cur, wpos_ff[cur]}] <= {op_ff.event_is_property, op_ff.event_word};
      if (state_ff == S_READ) rdata_ff <= ring[raddr];
   end

   // main datapath
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         active_ff  <= '0;
         now_ff     <= '0;
         out_vld_ff <= 1'b0;
         for (int i = 0; i < esq_pkg::Subscribers; i++) begin
            end_ff[i]  <= '0;
            wpos_ff[i] <= '0;
            rpos_ff[i] <= '0;
            fill_ff[i] <= '0;
         end
      end else begin
         state_ff   <= state_in;
         out_vld_ff <= out_vld_in;
         unique case (state_ff)
            S_IDLE: if (req.valid && req.ready) begin
               op_ff    <= req.data;
               cnt_ff   <= '0;
               found_ff <= 1'b0;
               fslot_ff <= '0;
               if (req.data.opcode == esq_pkg::OP_TICK && now_ff != 32'hFFFF_FFFF)
                  now_ff <= now_ff + 32'd1;
            end
            S_SCAN: begin
               cnt_ff <= cnt_ff + 1'b1;
               case (op_ff.opcode)
                  esq_pkg::OP_CREATE: if (!found_ff && !active_ff[cur]) begin
                     found_ff <= 1'b1;
                     fslot_ff <= cur;
                  end
                  esq_pkg::OP_PUSH: if (active_ff[cur] && !expired) begin
                     wpos_ff[cur] <= wpos_ff[cur] + 1'b1;
                     if (fill_ff[cur] < esq_pkg::FillBits'(esq_pkg::QueueDepth))
                        fill_ff[cur] <= fill_ff[cur] + 1'b1;
                     else rpos_ff[cur] <= rpos_ff[cur] + 1'b1;
                  end
                  default: if (active_ff[cur] && expired) active_ff[cur] <= 1'b0;
               endcase
            end
            S_FIN: begin
               out_ff <= fin_rsp;
               case (op_ff.opcode)
                  esq_pkg::OP_CREATE: if (found_ff) begin
                     active_ff[fslot_ff] <= 1'b1;
                     wpos_ff[fslot_ff]   <= '0;
                     rpos_ff[fslot_ff]   <= '0;
                     fill_ff[fslot_ff]   <= '0;
                     end_ff[fslot_ff]    <= new_end;
                  end
                  esq_pkg::OP_PULL: if (pull_live)
                     left_ff <= (fill_ff[idx] < pull_lim) ? fill_ff[idx] : pull_lim;
                  esq_pkg::OP_RENEW: if (in_range && active_ff[idx]) end_ff[idx] <= new_end;
                  esq_pkg::OP_UNSUB: if (in_range && active_ff[idx]) active_ff[idx] <= 1'b0;
                  default: ;
               endcase
            end
            S_READ: begin
               rpos_ff[idx] <= rpos_ff[idx] + 1'b1;
               fill_ff[idx] <= fill_ff[idx] - 1'b1;
            end
            S_EMIT: if (!out_vld_ff || rsp.ready) begin
               out_ff.pulled_event       <= rdata_ff[esq_pkg::EventBits-1:0];
               out_ff.pulled_is_property <= rdata_ff[esq_pkg::EventBits];
               out_ff.has_event          <= 1'b1;
               out_ff.last               <= (left_ff == 7'd1);
               left_ff                   <= left_ff - 7'd1;
            end
            default: ;
         endcase
      end
   end
endmodule
